// ===== src/wav_pcm16_stream_parser_assert.svh =====
// Assertion macros for the WAV PCM16 stream parser.
`ifndef WAV_PCM16_STREAM_PARSER_ASSERT_SVH
`define WAV_PCM16_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define WAVP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define WAVP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/wavp_pkg.sv =====
// Types and constants for the WAV PCM16 stream parser.
package wavp_pkg;

  typedef enum logic [6:0] {
    PH_PREAMBLE = 7'b0000001,
    PH_HEADER   = 7'b0000010,
    PH_FMT_BODY = 7'b0000100,
    PH_SKIP     = 7'b0001000,
    PH_PAD      = 7'b0010000,
    PH_STREAM   = 7'b0100000,
    PH_SILENT   = 7'b1000000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_FORMAT = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NOT_RIFF     = 3'd0,
    ERR_FMT_SMALL    = 3'd1,
    ERR_DATA_NO_FMT  = 3'd2,
    ERR_NOT_PCM      = 3'd3,
    ERR_NOT_MONO     = 3'd4,
    ERR_NOT_16BIT    = 3'd5,
    ERR_TRUNCATED    = 3'd6,
    ERR_NO_AUDIO     = 3'd7
  } err_t;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_EOS  = 1'b1
  } op_t;

  // Four-character codes as read little-endian
  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
  localparam logic [15:0] TAG_PCM      = 16'd1;
  localparam logic [15:0] MONO         = 16'd1;
  localparam logic [15:0] DEPTH_16     = 16'd16;

  localparam logic [31:0] PRE_RIFF_LAST = 32'd3;
  localparam logic [31:0] PRE_LAST      = 32'd11;
  localparam logic [31:0] HDR_ID_BYTES  = 32'd4;
  localparam logic [31:0] HDR_LAST      = 32'd7;

endpackage

// ===== src/wav_pcm16_stream_parser.sv =====
// WAV PCM16 mono stream parser: RIFF/WAVE header walk and sample extraction.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one transfer per byte of the
//   response body (in_op = 0, byte on in_stream_byte) or an end-of-stream
//   marker (in_op = 1). Result channel (out_valid/out_ready) carries at most
//   one result per input transfer: a format announcement with the sample rate
//   (kind 0) at the data chunk header, one signed 16-bit sample (kind 1) per
//   byte pair of audio, or one error (kind 2) after which the block is silent.
//   Latency: a result appears on out_* the cycle after the input transfer that
//   caused it. Throughput: one byte per cycle, barring a stall; the parse state
//   updates in a single pass from the input ports into the state and result
//   registers. in_ready = output register empty or being taken this cycle, so
//   a byte is accepted while a finished result is leaving; when the receiver
//   stalls with a result held, in_ready drops until that result is taken.
//   Reset (rst_n low, synchronous) returns to waiting for the RIFF preamble,
//   clears all captured format fields and empties the output register.
//   After an error or an end-of-stream marker every input transfer is taken
//   and ignored until the next reset.
`include "wav_pcm16_stream_parser_assert.svh"

module wav_pcm16_stream_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [0:0]            in_op,
  input  logic [7:0]            in_stream_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_kind,
  output logic signed [15:0]    out_sample,
  output logic [31:0]           out_rate_hz,
  output logic [2:0]            out_error_code
);
  import wavp_pkg::*;

  // parse state
  phase_t      phase_r, phase_nxt;
  logic [31:0] byte_count_r, byte_count_nxt;
  logic [31:0] chunk_id_r, chunk_id_nxt;
  logic [31:0] chunk_size_r, chunk_size_nxt;
  logic [15:0] format_tag_r, format_tag_nxt;
  logic [15:0] channel_count_r, channel_count_nxt;
  logic [31:0] rate_value_r, rate_value_nxt;
  logic [15:0] bit_depth_r, bit_depth_nxt;
  logic        fmt_seen_r, fmt_seen_nxt;
  logic        any_byte_seen_r, any_byte_seen_nxt;
  logic [7:0]  low_byte_r, low_byte_nxt;
  logic        low_byte_held_r, low_byte_held_nxt;
  logic        preamble_bad_r, preamble_bad_nxt;

  // output register
  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [15:0] out_sample_r;
  logic [31:0] out_rate_r;
  logic [2:0]  out_err_r;

  // result of this transfer
  logic        res_vld;
  kind_t       res_kind;
  logic [15:0] res_smp;
  logic [31:0] res_rate;
  err_t        res_err;

  logic        in_xfer;
  logic [31:0] byte_word;
  logic [4:0]  lane_sh;
  logic [31:0] id_new;
  logic [31:0] size_new;
  logic [31:0] cnt_inc;
  logic        body_end;
  logic [31:0] body_id;
  logic [31:0] body_size;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  assign byte_word = {24'd0, in_stream_byte};
  assign lane_sh   = {byte_count_r[1:0], 3'b000};
  assign cnt_inc   = byte_count_r + 32'd1;

  always_comb begin
    phase_nxt         = phase_r;
    byte_count_nxt    = byte_count_r;
    chunk_id_nxt      = chunk_id_r;
    chunk_size_nxt    = chunk_size_r;
    format_tag_nxt    = format_tag_r;
    channel_count_nxt = channel_count_r;
    rate_value_nxt    = rate_value_r;
    bit_depth_nxt     = bit_depth_r;
    fmt_seen_nxt      = fmt_seen_r;
    any_byte_seen_nxt = any_byte_seen_r;
    low_byte_nxt      = low_byte_r;
    low_byte_held_nxt = low_byte_held_r;
    preamble_bad_nxt  = preamble_bad_r;
    res_vld           = 1'b0;
    res_kind          = KIND_FORMAT;
    res_smp           = 16'd0;
    res_rate          = 32'd0;
    res_err           = ERR_NOT_RIFF;
    id_new            = chunk_id_r;
    size_new          = chunk_size_r;
    body_end          = 1'b0;
    body_id           = chunk_id_r;
    body_size         = chunk_size_r;

    if (phase_r == PH_SILENT) begin
      // absorbing: everything is dropped
    end else if (in_op == OP_EOS) begin
      if (phase_r == PH_STREAM) begin
        low_byte_held_nxt = 1'b0;
        phase_nxt         = PH_SILENT;
      end else begin
        phase_nxt = PH_SILENT;
        res_vld   = 1'b1;
        res_kind  = KIND_ERROR;
        res_err   = any_byte_seen_r ? ERR_TRUNCATED : ERR_NO_AUDIO;
      end
    end else begin
      any_byte_seen_nxt = 1'b1;
      unique case (phase_r)
        PH_PREAMBLE: begin
          id_new = ((byte_count_r[1:0] == 2'd0) ? 32'd0 : chunk_id_r)
                   | (byte_word << lane_sh);
          chunk_id_nxt = id_new;
          if (byte_count_r == PRE_RIFF_LAST && id_new != ID_RIFF) begin
            preamble_bad_nxt = 1'b1;
          end
          if (byte_count_r == PRE_LAST) begin
            if (preamble_bad_r || id_new != ID_WAVE) begin
              phase_nxt = PH_SILENT;
              res_vld   = 1'b1;
              res_kind  = KIND_ERROR;
              res_err   = ERR_NOT_RIFF;
            end else begin
              phase_nxt      = PH_HEADER;
              byte_count_nxt = 32'd0;
              chunk_id_nxt   = 32'd0;
              chunk_size_nxt = 32'd0;
            end
          end else begin
            byte_count_nxt = cnt_inc;
          end
        end
        PH_HEADER: begin
          if (byte_count_r < HDR_ID_BYTES) begin
            id_new = chunk_id_r | (byte_word << lane_sh);
          end else begin
            size_new = chunk_size_r | (byte_word << lane_sh);
          end
          chunk_id_nxt   = id_new;
          chunk_size_nxt = size_new;
          if (byte_count_r >= HDR_LAST) begin
            if (id_new == ID_DATA) begin
              res_vld   = 1'b1;
              res_kind  = KIND_ERROR;
              phase_nxt = PH_SILENT;
              // checks in priority order
              priority if (!fmt_seen_r)             res_err = ERR_DATA_NO_FMT;
              else if (format_tag_r != TAG_PCM)     res_err = ERR_NOT_PCM;
              else if (channel_count_r != MONO)     res_err = ERR_NOT_MONO;
              else if (bit_depth_r != DEPTH_16)     res_err = ERR_NOT_16BIT;
              else begin
                res_kind          = KIND_FORMAT;
                res_rate          = rate_value_r;
                phase_nxt         = PH_STREAM;
                low_byte_held_nxt = 1'b0;
              end
            end else begin
              byte_count_nxt = 32'd0;
              phase_nxt      = (id_new == ID_FMT) ? PH_FMT_BODY : PH_SKIP;
              if (size_new == 32'd0) begin
                body_end  = 1'b1;
                body_id   = id_new;
                body_size = size_new;
              end
            end
          end else begin
            byte_count_nxt = cnt_inc;
          end
        end
        PH_FMT_BODY: begin
          if (byte_count_r[31:4] == 28'd0) begin
            unique case (byte_count_r[3:0])
              4'd0:  format_tag_nxt[7:0]     = in_stream_byte;
              4'd1:  format_tag_nxt[15:8]    = in_stream_byte;
              4'd2:  channel_count_nxt[7:0]  = in_stream_byte;
              4'd3:  channel_count_nxt[15:8] = in_stream_byte;
              4'd4:  rate_value_nxt[7:0]     = in_stream_byte;
              4'd5:  rate_value_nxt[15:8]    = in_stream_byte;
              4'd6:  rate_value_nxt[23:16]   = in_stream_byte;
              4'd7:  rate_value_nxt[31:24]   = in_stream_byte;
              4'd14: bit_depth_nxt[7:0]      = in_stream_byte;
              4'd15: bit_depth_nxt[15:8]     = in_stream_byte;
              default: ;
            endcase
          end
          byte_count_nxt = cnt_inc;
          body_end       = (cnt_inc == chunk_size_r);
        end
        PH_SKIP: begin
          byte_count_nxt = cnt_inc;
          body_end       = (cnt_inc == chunk_size_r);
        end
        PH_PAD: begin
          phase_nxt      = PH_HEADER;
          byte_count_nxt = 32'd0;
          chunk_id_nxt   = 32'd0;
          chunk_size_nxt = 32'd0;
        end
        PH_STREAM: begin
          if (!low_byte_held_r) begin
            low_byte_nxt      = in_stream_byte;
            low_byte_held_nxt = 1'b1;
          end else begin
            low_byte_held_nxt = 1'b0;
            res_vld           = 1'b1;
            res_kind          = KIND_SAMPLE;
            res_smp           = {in_stream_byte, low_byte_r};
          end
        end
        default: phase_nxt = PH_SILENT;
      endcase

      // end of a fmt or skipped chunk body
      if (body_end) begin
        if (body_id == ID_FMT && body_size < FMT_MIN_SIZE) begin
          phase_nxt = PH_SILENT;
          res_vld   = 1'b1;
          res_kind  = KIND_ERROR;
          res_err   = ERR_FMT_SMALL;
        end else begin
          if (body_id == ID_FMT) begin
            fmt_seen_nxt = 1'b1;
          end
          if (body_size[0]) begin
            phase_nxt = PH_PAD;
          end else begin
            phase_nxt      = PH_HEADER;
            byte_count_nxt = 32'd0;
            chunk_id_nxt   = 32'd0;
            chunk_size_nxt = 32'd0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_PREAMBLE;
      byte_count_r    <= 32'd0;
      chunk_id_r      <= 32'd0;
      chunk_size_r    <= 32'd0;
      format_tag_r    <= 16'd0;
      channel_count_r <= 16'd0;
      rate_value_r    <= 32'd0;
      bit_depth_r     <= 16'd0;
      fmt_seen_r      <= 1'b0;
      any_byte_seen_r <= 1'b0;
      low_byte_r      <= 8'd0;
      low_byte_held_r <= 1'b0;
      preamble_bad_r  <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase_r         <= phase_nxt;
        byte_count_r    <= byte_count_nxt;
        chunk_id_r      <= chunk_id_nxt;
        chunk_size_r    <= chunk_size_nxt;
        format_tag_r    <= format_tag_nxt;
        channel_count_r <= channel_count_nxt;
        rate_value_r    <= rate_value_nxt;
        bit_depth_r     <= bit_depth_nxt;
        fmt_seen_r      <= fmt_seen_nxt;
        any_byte_seen_r <= any_byte_seen_nxt;
        low_byte_r      <= low_byte_nxt;
        low_byte_held_r <= low_byte_held_nxt;
        preamble_bad_r  <= preamble_bad_nxt;
        out_valid_r     <= res_vld;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded only when a result is produced
  always_ff @(posedge clk) begin
    if (in_xfer && res_vld) begin
      out_kind_r   <= res_kind;
      out_sample_r <= res_smp;
      out_rate_r   <= res_rate;
      out_err_r    <= (res_kind == KIND_ERROR) ? res_err : 3'd0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_sample     = out_sample_r;
  assign out_rate_hz    = out_rate_r;
  assign out_error_code = out_err_r;

  // An error result is final: the parser must already be silent.
  `WAVP_ASSERT_IMP(a_err_silent, out_valid_r && out_kind_r == KIND_ERROR, phase_r == PH_SILENT, "error result while parser still active")
  // A format announcement starts streaming with no byte held.
  `WAVP_ASSERT_IMP(a_fmt_stream, out_valid_r && out_kind_r == KIND_FORMAT, phase_r == PH_STREAM && !low_byte_held_r, "format result without entering stream phase")
  // Samples only come out of the stream phase, with the pair completed.
  `WAVP_ASSERT_IMP(a_smp_stream, out_valid_r && out_kind_r == KIND_SAMPLE, phase_r == PH_STREAM && !low_byte_held_r, "sample result outside stream phase")

endmodule
